>>> rtl/lsrs_pkg.sv
// Shared types, constants and the byte-wise CRC-32 function of the log segment scanner.
package lsrs_pkg;

	localparam int POS_BITS = 48;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	localparam logic [4:0] SEG_HDR_LAST = 5'd13;
	localparam logic [4:0] REC_HDR_LAST = 5'd25;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	localparam logic [7:0] REG_MAX_TOPIC = 8'd0;
	localparam logic [7:0] REG_MAX_PAYLOAD = 8'd1;
	localparam logic [7:0] REG_VERSION = 8'd2;
	localparam logic [7:0] REG_MAGIC = 8'd3;

	localparam logic [15:0] RST_MAX_TOPIC = 16'd1024;
	localparam logic [23:0] RST_MAX_PAYLOAD = 24'd1048576;
	localparam logic [15:0] RST_VERSION = 16'd1;
	localparam logic [31:0] RST_MAGIC = 32'h52544F49;

	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic [3:0] ST_CLEAN = 4'd0;
	localparam logic [3:0] ST_PARTIAL = 4'd1;
	localparam logic [3:0] ST_TOPIC = 4'd2;
	localparam logic [3:0] ST_PAYLOAD = 4'd3;
	localparam logic [3:0] ST_SEQUENCE = 4'd4;
	localparam logic [3:0] ST_TRUNCATED = 4'd5;
	localparam logic [3:0] ST_CRC = 4'd6;
	localparam logic [3:0] ST_SHORT = 4'd7;
	localparam logic [3:0] ST_MAGIC = 4'd8;
	localparam logic [3:0] ST_VERSION = 4'd9;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_file;
	} in_beat_t;

	typedef struct packed {
		logic        result_kind;
		logic [3:0]  status;
		logic [63:0] next_offset;
		logic [47:0] valid_end_position;
		logic [63:0] valid_records;
		logic        tail_discarded;
		logic        last_result;
	} out_beat_t;

	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> rtl/log_segment_recovery_scanner.sv
// Log segment recovery scanner: header and record checks with CRC-32, one byte per beat.
//
//   channel  direction  handshake               payload
//   in       in         in_valid / in_stall     in_data (in_beat_t)
//   out      out        out_valid / out_stall   out_data (out_beat_t)
//   cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each beat is registered, then checked combinationally against the scan state; one beat
// per cycle is taken while the input does not stall. A beat that ends a record and the
// file gives two results, which leave the four-entry result queue one at a time. The input
// stalls while a registered beat waits on a queue with fewer than two free entries. Reset
// restores register defaults and an empty scan.
module log_segment_recovery_scanner (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lsrs_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output lsrs_pkg::out_beat_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam logic [1:0] PH_SEG_HDR = 2'd0;
	localparam logic [1:0] PH_REC_HDR = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;
	localparam logic [1:0] PH_FAULT = 2'd3;

	logic [15:0] max_topic_q;
	logic [23:0] max_payload_q;
	logic [15:0] version_q;
	logic [31:0] magic_q;

	logic [1:0]                    phase_q, phase_d;
	logic [4:0]                    idx_q, idx_d;
	logic [63:0]                   base_q, base_d;
	logic [63:0]                   expect_q, expect_d;
	logic [63:0]                   rec_count_q, rec_count_d;
	logic [31:0]                   stored_q, stored_d;
	logic [15:0]                   topic_q, topic_d;
	logic [31:0]                   payload_q, payload_d;
	logic [24:0]                   remain_q, remain_d;
	logic [31:0]                   crc_q, crc_d;
	logic [lsrs_pkg::POS_BITS-1:0] pos_q, pos_d;
	logic [lsrs_pkg::POS_BITS-1:0] good_q, good_d;
	logic [3:0]                    fault_q, fault_d;
	logic                          mismatch_q, mismatch_d;

	lsrs_pkg::in_beat_t item_s1;
	logic               valid_s1;

	lsrs_pkg::out_beat_t                fifo_q [lsrs_pkg::FIFO_DEPTH];
	logic [lsrs_pkg::FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [lsrs_pkg::FIFO_CNT_BITS-1:0] count_q;

	logic                room, advance, pop;
	logic [1:0]          push_n;
	lsrs_pkg::out_beat_t res0, res1;

	assign cfg_ready = 1'b1;
	assign room = count_q <= lsrs_pkg::FIFO_CNT_BITS'(lsrs_pkg::FIFO_DEPTH - 2);
	assign advance = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign out_valid = count_q != '0;
	assign out_data = fifo_q[rd_ptr_q];
	assign pop = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_topic_q <= lsrs_pkg::RST_MAX_TOPIC;
			max_payload_q <= lsrs_pkg::RST_MAX_PAYLOAD;
			version_q <= lsrs_pkg::RST_VERSION;
			magic_q <= lsrs_pkg::RST_MAGIC;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lsrs_pkg::REG_MAX_TOPIC: max_topic_q <= cfg_data[15:0];
				lsrs_pkg::REG_MAX_PAYLOAD: max_payload_q <= cfg_data[23:0];
				lsrs_pkg::REG_VERSION: version_q <= cfg_data[15:0];
				lsrs_pkg::REG_MAGIC: magic_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_comb begin
		logic [7:0]                    b;
		logic [4:0]                    i;
		logic [2:0]                    lane;
		logic [7:0]                    want;
		logic [24:0]                   body_sum;
		logic                          rec_ok;
		logic [3:0]                    st;
		logic [63:0]                   good_wide;
		phase_d = phase_q;
		idx_d = idx_q;
		base_d = base_q;
		expect_d = expect_q;
		rec_count_d = rec_count_q;
		stored_d = stored_q;
		topic_d = topic_q;
		payload_d = payload_q;
		remain_d = remain_q;
		crc_d = crc_q;
		pos_d = pos_q;
		good_d = good_q;
		fault_d = fault_q;
		mismatch_d = mismatch_q;
		b = item_s1.data_byte;
		i = idx_q;
		lane = 3'd0;
		want = 8'd0;
		body_sum = '0;
		rec_ok = 1'b0;
		st = lsrs_pkg::ST_CLEAN;
		good_wide = '0;
		res0 = '0;
		res1 = '0;
		push_n = 2'd0;

		if (item_s1.has_byte) begin
			pos_d = pos_q + 1'b1;
			unique case (phase_q)
				PH_SEG_HDR: begin
					if (i < 5'd4) begin
						stored_d = ((i == 5'd0) ? 32'd0 : stored_q) | (32'(b) << {i[1:0], 3'b000});
					end else if (i < 5'd6) begin
						topic_d = ((i == 5'd4) ? 16'd0 : topic_q) | (16'(b) << {i[0], 3'b000});
					end else begin
						lane = 3'(i - 5'd6);
						base_d = ((i == 5'd6) ? 64'd0 : base_q) | (64'(b) << {lane, 3'b000});
					end
					if (i >= lsrs_pkg::SEG_HDR_LAST) begin
						if (stored_d != magic_q) begin
							phase_d = PH_FAULT;
							fault_d = lsrs_pkg::ST_MAGIC;
						end else if (topic_d != version_q) begin
							phase_d = PH_FAULT;
							fault_d = lsrs_pkg::ST_VERSION;
						end else begin
							expect_d = base_d;
							rec_count_d = '0;
							good_d = pos_d;
							phase_d = PH_REC_HDR;
							idx_d = '0;
						end
					end else begin
						idx_d = i + 1'b1;
					end
				end
				PH_REC_HDR: begin
					if (i == 5'd0) begin
						stored_d = '0;
						topic_d = '0;
						payload_d = '0;
						mismatch_d = 1'b0;
						crc_d = lsrs_pkg::CRC_INIT;
					end
					if (i < 5'd4) begin
						stored_d = stored_d | (32'(b) << {i[1:0], 3'b000});
					end else begin
						crc_d = lsrs_pkg::crc32_byte(crc_d, b);
					end
					if (i >= 5'd4 && i < 5'd12) begin
						lane = 3'(i - 5'd4);
						want = 8'(expect_q >> {lane, 3'b000});
						if (want != b) begin
							mismatch_d = 1'b1;
						end
					end else if (i == 5'd20 || i == 5'd21) begin
						topic_d = topic_d | (16'(b) << {i[0], 3'b000});
					end else if (i >= 5'd22 && i <= lsrs_pkg::REC_HDR_LAST) begin
						lane = 3'(i - 5'd22);
						payload_d = payload_d | (32'(b) << {lane[1:0], 3'b000});
					end
					if (i < lsrs_pkg::REC_HDR_LAST) begin
						idx_d = i + 1'b1;
					end else if (topic_d > max_topic_q) begin
						phase_d = PH_FAULT;
						fault_d = lsrs_pkg::ST_TOPIC;
					end else if (payload_d > 32'(max_payload_q)) begin
						phase_d = PH_FAULT;
						fault_d = lsrs_pkg::ST_PAYLOAD;
					end else if (mismatch_d) begin
						phase_d = PH_FAULT;
						fault_d = lsrs_pkg::ST_SEQUENCE;
					end else begin
						body_sum = 25'(topic_d) + 25'(payload_d[23:0]);
						remain_d = body_sum;
						if (body_sum == '0) begin
							rec_ok = 1'b1;
						end else begin
							phase_d = PH_BODY;
						end
					end
				end
				PH_BODY: begin
					crc_d = lsrs_pkg::crc32_byte(crc_q, b);
					remain_d = remain_q - 1'b1;
					if (remain_d == '0) begin
						rec_ok = 1'b1;
					end
				end
				PH_FAULT: ;
				default: ;
			endcase
		end

		// The record is accepted only once its checksum agrees.
		if (rec_ok) begin
			if (~crc_d != stored_d) begin
				rec_ok = 1'b0;
				phase_d = PH_FAULT;
				fault_d = lsrs_pkg::ST_CRC;
			end else begin
				expect_d = expect_q + 1'b1;
				rec_count_d = rec_count_q + 1'b1;
				good_d = pos_d;
				phase_d = PH_REC_HDR;
				idx_d = '0;
			end
		end

		good_wide = 64'(good_d);
		if (rec_ok) begin
			res0.result_kind = lsrs_pkg::KIND_RECORD;
			res0.status = lsrs_pkg::ST_CLEAN;
			res0.next_offset = expect_d;
			res0.valid_end_position = good_wide[47:0];
			res0.valid_records = rec_count_d;
			res0.tail_discarded = 1'b0;
			res0.last_result = !item_s1.end_of_file;
		end

		if (item_s1.end_of_file) begin
			unique case (phase_d)
				PH_SEG_HDR: st = lsrs_pkg::ST_SHORT;
				PH_REC_HDR: st = (idx_d == '0) ? lsrs_pkg::ST_CLEAN : lsrs_pkg::ST_PARTIAL;
				PH_BODY: st = lsrs_pkg::ST_TRUNCATED;
				default: st = fault_d;
			endcase
			res1.result_kind = lsrs_pkg::KIND_VERDICT;
			res1.status = st;
			res1.last_result = 1'b1;
			if (st < lsrs_pkg::ST_SHORT) begin
				res1.next_offset = expect_d;
				res1.valid_end_position = good_wide[47:0];
				res1.valid_records = rec_count_d;
				res1.tail_discarded = pos_d != good_d;
			end
			if (!rec_ok) begin
				res0 = res1;
			end
			phase_d = PH_SEG_HDR;
			idx_d = '0;
			base_d = '0;
			expect_d = '0;
			rec_count_d = '0;
			stored_d = '0;
			topic_d = '0;
			payload_d = '0;
			remain_d = '0;
			crc_d = lsrs_pkg::CRC_INIT;
			pos_d = '0;
			good_d = '0;
			fault_d = '0;
			mismatch_d = 1'b0;
		end

		push_n = 2'(rec_ok) + 2'(item_s1.end_of_file);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEG_HDR;
			idx_q <= '0;
			base_q <= '0;
			expect_q <= '0;
			rec_count_q <= '0;
			stored_q <= '0;
			topic_q <= '0;
			payload_q <= '0;
			remain_q <= '0;
			crc_q <= lsrs_pkg::CRC_INIT;
			pos_q <= '0;
			good_q <= '0;
			fault_q <= '0;
			mismatch_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			idx_q <= idx_d;
			base_q <= base_d;
			expect_q <= expect_d;
			rec_count_q <= rec_count_d;
			stored_q <= stored_d;
			topic_q <= topic_d;
			payload_q <= payload_d;
			remain_q <= remain_d;
			crc_q <= crc_d;
			pos_q <= pos_d;
			good_q <= good_d;
			fault_q <= fault_d;
			mismatch_q <= mismatch_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (advance && push_n == 2'd2) begin
			fifo_q[wr_ptr_q + 1'b1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (advance) begin
				wr_ptr_q <= wr_ptr_q + lsrs_pkg::FIFO_PTR_BITS'(push_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (advance ? lsrs_pkg::FIFO_CNT_BITS'(push_n) : '0)
				- lsrs_pkg::FIFO_CNT_BITS'(pop);
		end
	end

`ifndef SYNTHESIS
	// The result queue never overflows.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lsrs_pkg::FIFO_CNT_BITS'(lsrs_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	// A beat that ends the file leaves an empty scan behind.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.end_of_file |=> phase_q == PH_SEG_HDR && pos_q == '0)
		else $error("scan not restarted after end of file");

	// Once faulted, the scan stays faulted until the end of the file.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FAULT && !(advance && item_s1.end_of_file) |=> phase_q == PH_FAULT)
		else $error("fault state left before end of file");

	// Record results carry a clean status and no discarded tail.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind == lsrs_pkg::KIND_RECORD |->
		out_data.status == lsrs_pkg::ST_CLEAN && !out_data.tail_discarded)
		else $error("record result with verdict fields set");
`endif

endmodule
